>>> sv/mqptq_pkg.sv
// Shared types and codes for the multi-queue sorted priority task queue.
`default_nettype none

package mqptq_pkg;

   // Action codes carried on the request side.
   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_QUERY  = 2'd2;

   // Status codes returned on the response side.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_BADQ  = 2'd3;

   // Fixed payload that rides along with every stored entry.
   typedef struct packed {
      logic [7:0]  kind;
      logic [6:0]  length;
      logic [15:0] tag;
   } item_type;

   // Per-queue command issued by the top level for one accepted item.
   typedef struct packed {
      logic insert;
      logic pop;
   } queue_cmd_type;

endpackage

`default_nettype wire

>>> sv/mqptq_cell.sv
// One slot of a sorted queue: holds an entry and moves it left or right.
`default_nettype none

module mqptq_cell
   import mqptq_pkg::*;
#(
   parameter int LEVEL_BITS = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire queue_cmd_type         cmd,
   input  wire logic [LEVEL_BITS-1:0] new_level,
   input  wire item_type              new_item,
   input  wire logic                  left_le,
   input  wire logic                  left_valid,
   input  wire logic [LEVEL_BITS-1:0] left_level,
   input  wire item_type              left_item,
   input  wire logic                  right_valid,
   input  wire logic [LEVEL_BITS-1:0] right_level,
   input  wire item_type              right_item,
   output logic                       le,
   output logic                       valid,
   output logic [LEVEL_BITS-1:0]      level,
   output item_type                   item
);

   logic                  valid_ff, valid_in;
   logic [LEVEL_BITS-1:0] level_ff, level_in;
   item_type              item_ff, item_in;

   // This slot stays in place on an insert when its entry sorts at or before the new one.
   assign le = valid_ff && (level_ff <= new_level);

   always_comb begin
      valid_in = valid_ff;
      level_in = level_ff;
      item_in  = item_ff;
      if (cmd.insert) begin
         if (!le) begin
            if (left_le) begin
               valid_in = 1'b1;
               level_in = new_level;
               item_in  = new_item;
            end else begin
               valid_in = left_valid;
               level_in = left_level;
               item_in  = left_item;
            end
         end
      end else if (cmd.pop) begin
         valid_in = right_valid;
         level_in = right_level;
         item_in  = right_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      level_ff <= level_in;
      item_ff  <= item_in;
   end

   assign valid = valid_ff;
   assign level = level_ff;
   assign item  = item_ff;

endmodule

`default_nettype wire

>>> sv/mqptq_queue.sv
// One sorted queue: a chain of slot cells plus its fill count.
`default_nettype none

module mqptq_queue
   import mqptq_pkg::*;
#(
   parameter int SLOTS_PER_QUEUE = 16,
   parameter int LEVEL_BITS      = 8,
   localparam int CountBits      = $clog2(SLOTS_PER_QUEUE + 1)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire queue_cmd_type         cmd,
   input  wire logic [LEVEL_BITS-1:0] new_level,
   input  wire item_type              new_item,
   output logic [LEVEL_BITS-1:0]      head_level,
   output item_type                   head_item,
   output logic [CountBits-1:0]       count
);

   logic [CountBits-1:0]  count_ff, count_in;

   logic                  cell_le    [SLOTS_PER_QUEUE];
   logic                  cell_valid [SLOTS_PER_QUEUE];
   logic [LEVEL_BITS-1:0] cell_level [SLOTS_PER_QUEUE];
   item_type              cell_item  [SLOTS_PER_QUEUE];

   for (genvar i = 0; i < SLOTS_PER_QUEUE; i++) begin : g_cell
      logic                  l_le, l_valid, r_valid;
      logic [LEVEL_BITS-1:0] l_level, r_level;
      item_type              l_item, r_item;

      if (i == 0) begin : g_first
         // The head has no left neighbor: a non-staying head takes the new entry.
         assign l_le    = 1'b1;
         assign l_valid = 1'b0;
         assign l_level = new_level;
         assign l_item  = new_item;
      end else begin : g_inner
         assign l_le    = cell_le[i-1];
         assign l_valid = cell_valid[i-1];
         assign l_level = cell_level[i-1];
         assign l_item  = cell_item[i-1];
      end

      if (i == SLOTS_PER_QUEUE - 1) begin : g_last
         // The tail refills with an empty slot on a pop.
         assign r_valid = 1'b0;
         assign r_level = new_level;
         assign r_item  = new_item;
      end else begin : g_body
         assign r_valid = cell_valid[i+1];
         assign r_level = cell_level[i+1];
         assign r_item  = cell_item[i+1];
      end

      mqptq_cell #(
         .LEVEL_BITS (LEVEL_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .new_level   (new_level),
         .new_item    (new_item),
         .left_le     (l_le),
         .left_valid  (l_valid),
         .left_level  (l_level),
         .left_item   (l_item),
         .right_valid (r_valid),
         .right_level (r_level),
         .right_item  (r_item),
         .le          (cell_le[i]),
         .valid       (cell_valid[i]),
         .level       (cell_level[i]),
         .item        (cell_item[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + CountBits'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CountBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head_level = cell_level[0];
   assign head_item  = cell_item[0];
   assign count      = count_ff;

endmodule

`default_nettype wire

>>> sv/multi_queue_priority_task_queue_top.sv
// Top level of the multi-queue sorted priority task queue.
//
//   Channel | Direction | tdata fields (low bit up)              | tuser fields
//   req_    | in        | level, kind, length, tag                | action, queue_select
//   rsp_    | out       | status, queue_empty, level, kind,       | (none)
//           |           | length, tag, entry_count                |
//
// For each insert or pop that changes the selected queue, the slot cells that move
// do so in the same cycle in which the response lands in the output register.
// A new item is taken every cycle as long as that register is free or is
// being emptied in the same cycle, so a stalled response holds the request side.
// The reset is synchronous: it clears the slot valid bits, the fill counts
// and the response valid flag; slot payloads are left as they are.
`default_nettype none

module multi_queue_priority_task_queue_top
   import mqptq_pkg::*;
#(
   parameter int QUEUE_COUNT     = 3,
   parameter int SLOTS_PER_QUEUE = 16,
   parameter int LEVEL_BITS      = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // item_level, item_kind, item_length, item_tag
   input  wire logic [3:0]  req_tuser,   // action, queue_select
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata    // status, queue_empty, out_level, out_kind,
                                         // out_length, out_tag, entry_count
);

   localparam int CountBits = $clog2(SLOTS_PER_QUEUE + 1);

   // Request fields.
   logic [1:0]            req_action;
   logic [1:0]            req_queue_select;
   logic [LEVEL_BITS-1:0] req_level;
   item_type              req_item;

   assign req_action       = req_tuser[1:0];
   assign req_queue_select = req_tuser[3:2];
   assign req_level        = LEVEL_BITS'(req_tdata[7:0]);
   assign req_item.kind    = req_tdata[15:8];
   assign req_item.length  = req_tdata[22:16];
   assign req_item.tag     = req_tdata[38:23];

   logic fire;
   assign fire = req_tvalid && req_tready;

   // Per-queue views.
   logic                  q_hit   [QUEUE_COUNT];
   queue_cmd_type         q_cmd   [QUEUE_COUNT];
   logic [LEVEL_BITS-1:0] q_level [QUEUE_COUNT];
   item_type              q_item  [QUEUE_COUNT];
   logic [CountBits-1:0]  q_count [QUEUE_COUNT];

   // Selected queue's state before the item is applied.
   logic                  sel_bad;
   logic [LEVEL_BITS-1:0] sel_level;
   item_type              sel_item;
   logic [CountBits-1:0]  sel_count;
   logic                  sel_full;
   logic                  sel_empty;
   logic                  do_insert;
   logic                  do_pop;

   always_comb begin
      sel_level = '0;
      sel_item  = '0;
      sel_count = '0;
      for (int g = 0; g < QUEUE_COUNT; g++) begin
         if (q_hit[g]) begin
            sel_level = sel_level | q_level[g];
            sel_item  = sel_item | q_item[g];
            sel_count = sel_count | q_count[g];
         end
      end
   end

   assign sel_bad   = (32'(req_queue_select) >= QUEUE_COUNT);
   assign sel_full  = (32'(sel_count) == SLOTS_PER_QUEUE);
   assign sel_empty = (sel_count == '0);
   assign do_insert = !sel_bad && (req_action == ACT_INSERT) && !sel_full;
   assign do_pop    = !sel_bad && (req_action == ACT_POP) && !sel_empty;

   for (genvar g = 0; g < QUEUE_COUNT; g++) begin : g_queue
      assign q_hit[g]        = (32'(req_queue_select) == g);
      assign q_cmd[g].insert = fire && q_hit[g] && do_insert;
      assign q_cmd[g].pop    = fire && q_hit[g] && do_pop;

      mqptq_queue #(
         .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE),
         .LEVEL_BITS      (LEVEL_BITS)
      ) u_queue (
         .clock      (clock),
         .reset      (reset),
         .cmd        (q_cmd[g]),
         .new_level  (req_level),
         .new_item   (req_item),
         .head_level (q_level[g]),
         .head_item  (q_item[g]),
         .count      (q_count[g])
      );
   end

   // Response formed from the selected queue; the head is read before it shifts.
   logic [1:0]           rsp_status;
   logic [CountBits-1:0] count_after;
   logic [7:0]           rsp_level;
   item_type             rsp_item;
   logic [4:0]           rsp_count;
   logic                 rsp_queue_empty;

   always_comb begin
      rsp_status  = ST_OK;
      count_after = sel_count;
      rsp_level   = '0;
      rsp_item    = '0;
      if (sel_bad) begin
         rsp_status = ST_BADQ;
      end else begin
         case (req_action)
            ACT_INSERT: begin
               if (sel_full) begin
                  rsp_status = ST_FULL;
               end else begin
                  count_after = sel_count + CountBits'(1);
               end
            end
            ACT_POP: begin
               if (sel_empty) begin
                  rsp_status = ST_EMPTY;
               end else begin
                  count_after = sel_count - CountBits'(1);
                  rsp_level   = 8'(sel_level);
                  rsp_item    = sel_item;
               end
            end
            default: begin
               // Query, and the unused action code, leave the queue alone.
               rsp_status = ST_OK;
            end
         endcase
      end
      rsp_count       = sel_bad ? 5'd0 : 5'(count_after);
      rsp_queue_empty = !sel_bad && (count_after == '0);
   end

   // Output register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   assign req_tready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, rsp_count, rsp_item.tag, rsp_item.length, rsp_item.kind,
                         rsp_level, rsp_queue_empty, rsp_status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> dv/mqptq_response_checker.sv
// Response checker for the multi-queue priority task queue: mirrors the queues and compares.
`timescale 1ns / 1ps

module mqptq_response_checker
   import mqptq_pkg::*;
#(
   parameter int NUM_QUEUES = 3,
   parameter int SLOTS      = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,
   input  wire logic [3:0]  req_tuser,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [47:0] rsp_tdata,
   output int               mismatch_count,
   output int               responses_owed
);

   // One response item, laid out as on rsp_tdata from the highest bit down.
   typedef struct packed {
      logic [4:0]  count;
      logic [15:0] tag;
      logic [6:0]  length;
      logic [7:0]  kind;
      logic [7:0]  level;
      logic        queue_empty;
      logic [1:0]  status;
   } queue_rsp_type;

   // Mirror of the stored entries; slots 0 .. fill-1 of each queue are in service order.
   logic [7:0]  mirror_level  [NUM_QUEUES][SLOTS];
   logic [7:0]  mirror_kind   [NUM_QUEUES][SLOTS];
   logic [6:0]  mirror_length [NUM_QUEUES][SLOTS];
   logic [15:0] mirror_tag    [NUM_QUEUES][SLOTS];
   int          fill          [NUM_QUEUES];

   queue_rsp_type owed_rsp[$];

   initial begin
      mismatch_count = 0;
      responses_owed = 0;
   end

   // Applies one command to the mirror and returns the response it must produce.
   function automatic queue_rsp_type apply_command(logic [1:0] action, logic [1:0] qsel,
                                                   logic [7:0] level, logic [7:0] kind,
                                                   logic [6:0] length, logic [15:0] tag);
      queue_rsp_type r;
      int n;
      int pos;
      r = '0;
      if (qsel >= NUM_QUEUES) begin
         r.status = ST_BADQ;
      end else begin
         n = fill[qsel];
         if (action == ACT_INSERT) begin
            if (n >= SLOTS) begin
               r.status = ST_FULL;
            end else begin
               // Equal levels go behind the ones already stored.
               pos = 0;
               while (pos < n && mirror_level[qsel][pos] <= level) pos++;
               for (int i = n; i > pos; i--) begin
                  mirror_level[qsel][i]  = mirror_level[qsel][i-1];
                  mirror_kind[qsel][i]   = mirror_kind[qsel][i-1];
                  mirror_length[qsel][i] = mirror_length[qsel][i-1];
                  mirror_tag[qsel][i]    = mirror_tag[qsel][i-1];
               end
               mirror_level[qsel][pos]  = level;
               mirror_kind[qsel][pos]   = kind;
               mirror_length[qsel][pos] = length;
               mirror_tag[qsel][pos]    = tag;
               n++;
               r.status = ST_OK;
            end
         end else if (action == ACT_POP) begin
            if (n == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.level  = mirror_level[qsel][0];
               r.kind   = mirror_kind[qsel][0];
               r.length = mirror_length[qsel][0];
               r.tag    = mirror_tag[qsel][0];
               for (int i = 1; i < n; i++) begin
                  mirror_level[qsel][i-1]  = mirror_level[qsel][i];
                  mirror_kind[qsel][i-1]   = mirror_kind[qsel][i];
                  mirror_length[qsel][i-1] = mirror_length[qsel][i];
                  mirror_tag[qsel][i-1]    = mirror_tag[qsel][i];
               end
               n--;
               r.status = ST_OK;
            end
         end else begin
            r.status = ST_OK;
         end
         fill[qsel] = n;
         r.queue_empty = (n == 0);
         r.count       = n[4:0];
      end
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
   endtask

   always @(posedge clock) begin
      queue_rsp_type got;
      queue_rsp_type want;
      if (reset) begin
         owed_rsp.delete();
         for (int q = 0; q < NUM_QUEUES; q++) fill[q] = 0;
      end else begin
         // The response at this edge belongs to an earlier request, so check it first.
         if (rsp_tvalid && rsp_tready) begin
            got = queue_rsp_type'(rsp_tdata[46:0]);
            if (owed_rsp.size() == 0) begin
               report_mismatch($sformatf("response 0x%0h with none outstanding", rsp_tdata));
            end else begin
               want = owed_rsp.pop_front();
               check_field("status", got.status, want.status);
               check_field("queue_empty", got.queue_empty, want.queue_empty);
               check_field("out_level", got.level, want.level);
               check_field("out_kind", got.kind, want.kind);
               check_field("out_length", got.length, want.length);
               check_field("out_tag", got.tag, want.tag);
               check_field("entry_count", got.count, want.count);
            end
         end
         if (req_tvalid && req_tready)
            owed_rsp.push_back(apply_command(req_tuser[1:0], req_tuser[3:2], req_tdata[7:0],
                                             req_tdata[15:8], req_tdata[22:16],
                                             req_tdata[38:23]));
      end
      responses_owed <= owed_rsp.size();
   end

endmodule

>>> dv/tb_multi_queue_priority_task_queue_top.sv
// Testbench top for the multi-queue priority task queue: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_multi_queue_priority_task_queue_top
   import mqptq_pkg::*;
();

   localparam int NUM_QUEUES = 3;
   localparam int SLOTS      = 16;

   // The spare action code behaves like a query, and queue index three is out of range.
   localparam logic [1:0] ACT_SPARE = 2'd3;
   localparam logic [1:0] BAD_QUEUE = 2'd3;

   // Cycles without any accepted item before the run is declared hung. The longest
   // legal quiet stretch is the receiver hold-off below, far shorter than this.
   localparam int STUCK_LIMIT  = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 270;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // item_level, item_kind, item_length, item_tag
   logic [3:0]  req_tuser = '0;   // action, queue_select
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // status, queue_empty, out_level, out_kind,
                                  // out_length, out_tag, entry_count

   int mismatch_count;
   int responses_owed;

   // Idle and stall odds in percent, set per phase by the stimulus process.
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;

   // The stimulus process asks for a long receiver hold-off by bumping hold_asked;
   // the receiver process serves each request once and counts the cycles itself.
   int hold_asked  = 0;
   int hold_served = 0;
   int hold_left   = 0;
   int stuck_cycles = 0;

   multi_queue_priority_task_queue_top #(
      .QUEUE_COUNT    (NUM_QUEUES),
      .SLOTS_PER_QUEUE(SLOTS),
      .LEVEL_BITS     (8)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   mqptq_response_checker #(
      .NUM_QUEUES(NUM_QUEUES),
      .SLOTS     (SLOTS)
   ) u_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .mismatch_count(mismatch_count),
      .responses_owed(responses_owed)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Receiver: random stalls at the phase's odds, or a long hold-off when asked.
   // While it holds, the output register stays full and the request side backs up.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_served != hold_asked) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   // Watchdog: any accepted item on either side restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("** multi_queue_priority_task_queue_top: FAILED **");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Offers one request item, with random idle cycles ahead of it, and returns at the
   // edge where it is accepted. The next call drives valid once in that same step, so
   // back-to-back items keep valid high without a glitch.
   task automatic send_command(logic [1:0] action, logic [1:0] qsel, logic [7:0] level,
                               logic [7:0] kind, logic [6:0] length, logic [15:0] tag);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, tag, length, kind, level};
      req_tuser  <= {qsel, action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // One random command. Levels lean toward a few small values so that ties, and
   // with them the arrival-order rule, come up often; the extremes are mixed in.
   task automatic send_random_command(int insert_pct);
      int roll;
      logic [1:0] action;
      logic [1:0] qsel;
      logic [7:0] level;
      roll = $urandom_range(99);
      if (roll < 3)
         action = ACT_SPARE;
      else if (roll < 12)
         action = ACT_QUERY;
      else if ($urandom_range(99) < insert_pct)
         action = ACT_INSERT;
      else
         action = ACT_POP;
      qsel = ($urandom_range(99) < 5) ? BAD_QUEUE : 2'($urandom_range(NUM_QUEUES - 1));
      case ($urandom_range(3))
         0, 1: level = 8'($urandom_range(3));
         2: level = 8'($urandom_range(255));
         default: level = $urandom_range(1) ? 8'd255 : 8'd0;
      endcase
      send_command(action, qsel, level, 8'($urandom_range(255)), 7'($urandom_range(100)),
                   16'($urandom_range(65535)));
   endtask

   initial begin
      int insert_pct;
      int fill_level;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Empty queue behavior first: a query, then a pop from nothing.
      send_command(ACT_QUERY, 2'd0, 8'd0, 8'd0, 7'd0, 16'd0);
      send_command(ACT_POP, 2'd0, 8'd0, 8'd0, 7'd0, 16'd0);
      // The out-of-range queue index on insert, pop and query; nothing may change.
      send_command(ACT_INSERT, BAD_QUEUE, 8'd9, 8'hff, 7'd100, 16'hffff);
      send_command(ACT_POP, BAD_QUEUE, 8'd0, 8'd0, 7'd0, 16'd0);
      send_command(ACT_QUERY, BAD_QUEUE, 8'd0, 8'd0, 7'd0, 16'd0);
      send_command(ACT_SPARE, 2'd1, 8'hff, 8'hff, 7'd100, 16'hffff);

      // Fill queue 2 to the brim: the field extremes first, then a run of equal levels
      // tagged in arrival order, then random levels. One more insert must be refused.
      for (int i = 0; i < SLOTS; i++) begin
         if (i == 0)
            send_command(ACT_INSERT, 2'd2, 8'd255, 8'd255, 7'd100, 16'hffff);
         else if (i == 1)
            send_command(ACT_INSERT, 2'd2, 8'd0, 8'd0, 7'd0, 16'h0000);
         else if (i < 10)
            send_command(ACT_INSERT, 2'd2, 8'd7, 8'(i), 7'(i), 16'(i));
         else
            send_command(ACT_INSERT, 2'd2, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         7'($urandom_range(100)), 16'($urandom_range(65535)));
      end
      send_command(ACT_INSERT, 2'd2, 8'd1, 8'h55, 7'd42, 16'h1234);
      send_command(ACT_POP, 2'd2, 8'd0, 8'd0, 7'd0, 16'd0);
      send_command(ACT_QUERY, 2'd2, 8'd0, 8'd0, 7'd0, 16'd0);
      send_command(ACT_SPARE, 2'd2, 8'd0, 8'd0, 7'd0, 16'd0);

      // Random part in four phases of idle and stall odds. Within a phase the insert share
      // changes every 24 items, so queues swing between full and empty.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 54; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 54; end
            default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
         endcase
         insert_pct = 50;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 24 == 0) begin
               fill_level = $urandom_range(2);
               insert_pct = (fill_level == 0) ? 25 : (fill_level == 1) ? 50 : 85;
            end
            // In the phase without idling or stalls, hold the receiver off once mid-way while
            // requests keep coming.
            if (phase == 0 && n == 100) hold_asked++;
            send_random_command(insert_pct);
         end
      end
      req_tvalid <= 1'b0;

      // Let the last request's expectation register, wait for every response, then
      // give the output register time to show anything stray.
      @(posedge clock);
      while (responses_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      if (mismatch_count == 0 && responses_owed == 0)
         $display("** multi_queue_priority_task_queue_top: PASSED **");
      else
         $display("** multi_queue_priority_task_queue_top: FAILED **");
      $finish;
   end

endmodule

>>> files.f
sv/mqptq_pkg.sv
sv/mqptq_cell.sv
sv/mqptq_queue.sv
sv/multi_queue_priority_task_queue_top.sv
dv/mqptq_response_checker.sv
dv/tb_multi_queue_priority_task_queue_top.sv
